@@ src/wrp_pkg.sv @@
// Shared types and constants for the WAV RIFF header parser.
package wrp_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_RIFF  = 3'd1,
    ST_NOT_WAVE  = 3'd2,
    ST_NON_PCM   = 3'd3,
    ST_NO_FMT    = 3'd4,
    ST_NO_DATA   = 3'd5,
    ST_TRUNCATED = 3'd6,
    ST_SHORT_FMT = 3'd7
  } status_t;

  // One parse result request
  typedef struct packed {
    logic        hit;
    status_t     status;
    logic [15:0] channels;
    logic [31:0] rate_hz;
    logic [15:0] sample_bits;
    logic [31:0] payload_len;
    logic [31:0] data_offset;
  } result_t;

  localparam logic [31:0] TAG_RIFF = {8'h52, 8'h49, 8'h46, 8'h46};
  localparam logic [31:0] TAG_WAVE = {8'h57, 8'h41, 8'h56, 8'h45};
  localparam logic [31:0] TAG_FMT  = {8'h66, 8'h6D, 8'h74, 8'h20};
  localparam logic [31:0] TAG_DATA = {8'h64, 8'h61, 8'h74, 8'h61};

  localparam logic [32:0] POS_MAX      = 33'h1_FFFF_FFFF;
  localparam logic [3:0]  HDR_LAST     = 4'd7;
  localparam logic [3:0]  RIFF_LAST    = 4'd11;
  localparam logic [3:0]  FMT_LAST     = 4'd15;
  localparam logic [33:0] HDR_LEN      = 34'd8;
  localparam logic [31:0] FMT_MIN      = 32'd16;
  localparam logic [15:0] PCM_CODE     = 16'd1;

endpackage

@@ src/wav_riff_header_parser.sv @@
// WAV RIFF header parser top level: byte input channel, result output register.
// A result is valid in the cycle after the byte that completes it is accepted.
// Throughput: one byte per cycle, limited only by the single-entry result register.
// A byte is taken while the result register is empty or being drained in that cycle.
// Reset (rst_n low, synchronous) returns the parser to waiting for a first byte
// and empties the result register; no clearing pass is needed.
module wav_riff_header_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_in,
  input  logic        in_first_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [15:0] out_channels,
  output logic [31:0] out_rate_hz,
  output logic [15:0] out_sample_bits,
  output logic [31:0] out_payload_len,
  output logic [31:0] out_data_offset
);

  logic             in_take;
  logic             out_valid_r, out_valid_nxt;
  wrp_pkg::result_t res;
  wrp_pkg::result_t res_r;

  // Accept while the result register is free or draining
  assign in_ready = !out_valid_r || out_ready;
  assign in_take  = in_valid && in_ready;

  wrp_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_take  (in_take),
    .in_byte  (in_byte_in),
    .in_first (in_first_byte),
    .in_last  (in_last_byte),
    .res      (res)
  );

  // Load a new result request or drop the delivered one
  assign out_valid_nxt = res.hit ? 1'b1 : (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.hit) begin
      res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = res_r.status;
  assign out_channels    = res_r.channels;
  assign out_rate_hz     = res_r.rate_hz;
  assign out_sample_bits = res_r.sample_bits;
  assign out_payload_len = res_r.payload_len;
  assign out_data_offset = res_r.data_offset;

`ifndef SYNTHESIS
  // A result request only comes with an accepted byte
  a_hit_on_take: assert property (@(posedge clk) disable iff (!rst_n)
    res.hit |-> in_take)
    else $error("result raised without an accepted byte");

  // A raised result is presented next cycle
  a_hit_shown: assert property (@(posedge clk) disable iff (!rst_n)
    res.hit |=> out_valid)
    else $error("result request lost");

  // Error results carry zero fields
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != wrp_pkg::ST_OK) |->
      (out_channels == '0 && out_rate_hz == '0 && out_sample_bits == '0 &&
       out_payload_len == '0 && out_data_offset == '0))
    else $error("error result with nonzero fields");

  // Empty result register never blocks input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");
`endif

endmodule

@@ src/wrp_parser.sv @@
// Byte-wise RIFF/WAVE chunk walker: holds the parse state, raises one result per file.
module wrp_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_take,
  input  logic [7:0]        in_byte,
  input  logic              in_first,
  input  logic              in_last,
  output wrp_pkg::result_t  res
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_RIFF,
    PH_CHDR,
    PH_FMT,
    PH_SKIP,
    PH_DONE
  } phase_t;

  phase_t      phase_r, phase_nxt, ph_cur;
  logic [32:0] file_pos_r, file_pos_nxt;
  logic [32:0] riff_limit_r, riff_limit_nxt;
  logic [32:0] chunk_end_r, chunk_end_nxt;
  logic [31:0] chunk_tag_r, chunk_tag_nxt;
  logic [31:0] chunk_len_r, chunk_len_nxt;
  logic [15:0] format_code_r, format_code_nxt;
  logic [15:0] chan_count_r, chan_count_nxt;
  logic [31:0] rate_value_r, rate_value_nxt;
  logic [15:0] width_value_r, width_value_nxt;
  logic [3:0]  byte_idx_r, byte_idx_nxt, idx_cur;

  logic          restart, active;
  logic [33:0]   pos_inc, hdr_sum, end_sum;
  logic          go_body, go_next, emit_en;
  wrp_pkg::status_t emit_code;

  always_comb begin
    restart = in_take && in_first;

    // Restart clears the parse and opens the RIFF header
    phase_nxt       = restart ? PH_RIFF : phase_r;
    file_pos_nxt    = restart ? '0 : file_pos_r;
    riff_limit_nxt  = restart ? '0 : riff_limit_r;
    chunk_end_nxt   = restart ? '0 : chunk_end_r;
    chunk_tag_nxt   = restart ? '0 : chunk_tag_r;
    chunk_len_nxt   = restart ? '0 : chunk_len_r;
    format_code_nxt = restart ? '0 : format_code_r;
    chan_count_nxt  = restart ? '0 : chan_count_r;
    rate_value_nxt  = restart ? '0 : rate_value_r;
    width_value_nxt = restart ? '0 : width_value_r;
    byte_idx_nxt    = restart ? '0 : byte_idx_r;

    ph_cur    = phase_nxt;
    idx_cur   = byte_idx_nxt;
    active    = in_take && (ph_cur != PH_IDLE) && (ph_cur != PH_DONE);
    pos_inc   = '0;
    hdr_sum   = '0;
    end_sum   = '0;
    go_body   = 1'b0;
    go_next   = 1'b0;
    emit_en   = 1'b0;
    emit_code = wrp_pkg::ST_OK;

    if (active) begin
      // Advance offset and header counter
      byte_idx_nxt = idx_cur + 4'd1;
      pos_inc      = {1'b0, file_pos_nxt} + 34'd1;
      file_pos_nxt = pos_inc[33] ? wrp_pkg::POS_MAX : pos_inc[32:0];

      unique case (ph_cur)
        PH_RIFF: begin
          if (idx_cur < 4'd4) begin
            chunk_tag_nxt = {chunk_tag_nxt[23:0], in_byte};
          end else if (idx_cur < 4'd8) begin
            chunk_len_nxt = {in_byte, chunk_len_nxt[31:8]};
            if (idx_cur == 4'd7) begin
              riff_limit_nxt = {1'b0, chunk_len_nxt} + 33'd8;
            end
          end else begin
            chunk_len_nxt = {chunk_len_nxt[23:0], in_byte};
            if (idx_cur == wrp_pkg::RIFF_LAST) begin
              if (chunk_tag_nxt != wrp_pkg::TAG_RIFF) begin
                emit_en   = 1'b1;
                emit_code = wrp_pkg::ST_NOT_RIFF;
              end else if (chunk_len_nxt != wrp_pkg::TAG_WAVE) begin
                emit_en   = 1'b1;
                emit_code = wrp_pkg::ST_NOT_WAVE;
              end else begin
                go_next = 1'b1;
              end
            end
          end
        end
        PH_CHDR: begin
          if (idx_cur < 4'd4) begin
            chunk_tag_nxt = {chunk_tag_nxt[23:0], in_byte};
          end else begin
            chunk_len_nxt = {in_byte, chunk_len_nxt[31:8]};
            if (idx_cur == wrp_pkg::HDR_LAST) begin
              // End of chunk body plus pad, saturated
              end_sum = {1'b0, file_pos_nxt} + {2'b00, chunk_len_nxt}
                        + {33'd0, chunk_len_nxt[0]};
              chunk_end_nxt = (end_sum > {1'b0, wrp_pkg::POS_MAX}) ?
                              wrp_pkg::POS_MAX : end_sum[32:0];
              if (chunk_tag_nxt == wrp_pkg::TAG_FMT) begin
                if (chunk_len_nxt < wrp_pkg::FMT_MIN) begin
                  emit_en   = 1'b1;
                  emit_code = wrp_pkg::ST_SHORT_FMT;
                end else begin
                  phase_nxt    = PH_FMT;
                  byte_idx_nxt = '0;
                end
              end else if (chunk_tag_nxt == wrp_pkg::TAG_DATA) begin
                emit_en   = 1'b1;
                emit_code = (chan_count_nxt == '0) ? wrp_pkg::ST_NO_FMT : wrp_pkg::ST_OK;
              end else begin
                go_body = 1'b1;
              end
            end
          end
        end
        PH_FMT: begin
          if (idx_cur < 4'd2) begin
            format_code_nxt = {in_byte, format_code_nxt[15:8]};
          end else if (idx_cur < 4'd4) begin
            chan_count_nxt = {in_byte, chan_count_nxt[15:8]};
          end else if (idx_cur < 4'd8) begin
            rate_value_nxt = {in_byte, rate_value_nxt[31:8]};
          end else if (idx_cur >= 4'd14) begin
            width_value_nxt = {in_byte, width_value_nxt[15:8]};
          end
          if (idx_cur == wrp_pkg::FMT_LAST) begin
            if (format_code_nxt != wrp_pkg::PCM_CODE) begin
              emit_en   = 1'b1;
              emit_code = wrp_pkg::ST_NON_PCM;
            end else begin
              go_body = 1'b1;
            end
          end
        end
        default: begin
          // Skip body bytes until the chunk end
          if (file_pos_nxt >= chunk_end_nxt) begin
            go_next = 1'b1;
          end
        end
      endcase

      // Finish the body or fall through to the next chunk
      if (go_body) begin
        if (file_pos_nxt >= chunk_end_nxt) begin
          go_next = 1'b1;
        end else begin
          phase_nxt = PH_SKIP;
        end
      end

      // Open a chunk header only if it fits in the RIFF extent
      hdr_sum = {1'b0, file_pos_nxt} + wrp_pkg::HDR_LEN;
      if (go_next) begin
        if (hdr_sum > {1'b0, riff_limit_nxt}) begin
          emit_en   = 1'b1;
          emit_code = wrp_pkg::ST_NO_DATA;
        end else begin
          phase_nxt    = PH_CHDR;
          byte_idx_nxt = '0;
        end
      end

      // File ended before any result
      if (!emit_en && in_last) begin
        emit_en   = 1'b1;
        emit_code = wrp_pkg::ST_TRUNCATED;
      end

      if (emit_en) begin
        phase_nxt = PH_DONE;
      end
    end

    // Build the result request; fields are zero on error
    res                 = '0;
    res.hit             = emit_en;
    res.status          = emit_code;
    if (emit_code == wrp_pkg::ST_OK) begin
      res.channels    = chan_count_nxt;
      res.rate_hz     = rate_value_nxt;
      res.sample_bits = width_value_nxt;
      res.payload_len = chunk_len_nxt;
      res.data_offset = file_pos_nxt[32] ? 32'hFFFF_FFFF : file_pos_nxt[31:0];
    end
  end

  // Hold parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      file_pos_r    <= '0;
      riff_limit_r  <= '0;
      chunk_end_r   <= '0;
      chunk_tag_r   <= '0;
      chunk_len_r   <= '0;
      format_code_r <= '0;
      chan_count_r  <= '0;
      rate_value_r  <= '0;
      width_value_r <= '0;
      byte_idx_r    <= '0;
    end else begin
      phase_r       <= phase_nxt;
      file_pos_r    <= file_pos_nxt;
      riff_limit_r  <= riff_limit_nxt;
      chunk_end_r   <= chunk_end_nxt;
      chunk_tag_r   <= chunk_tag_nxt;
      chunk_len_r   <= chunk_len_nxt;
      format_code_r <= format_code_nxt;
      chan_count_r  <= chan_count_nxt;
      rate_value_r  <= rate_value_nxt;
      width_value_r <= width_value_nxt;
      byte_idx_r    <= byte_idx_nxt;
    end
  end

endmodule
